// File: rtl/weo_pkg.sv
// Shared types, constants and tables for the wheel encoder odometry block.
package weo_pkg;

  localparam int unsigned CountBits   = 16;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepBits    = $clog2(CordicSteps + 1);

  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindRead   = 2'd1;
  localparam logic [1:0] KindClear  = 2'd2;

  localparam logic [0:0] RegCmPerPulse   = 1'd0;
  localparam logic [0:0] RegHeadingGain  = 1'd1;

  localparam logic signed [33:0] CordicX0 = 34'sd652032874;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StDist,
    StTurn,
    StHead,
    StCordic,
    StMulX,
    StMulY,
    StOut
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sample;
    logic clear;
    logic dist_calc;
    logic turn;
    logic head;
    logic cordic_step;
    logic mul_x;
    logic mul_y;
    logic finish;
  } cmd_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/weo_ctrl.sv
// Controller state machine that passes on sample and clear beats and sequences each read beat through the datapath.
module weo_ctrl
  import weo_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic       in_ready_o,
  input  logic       out_busy_i,
  output cmd_t       cmd_o
);

  state_e              state_q, state_d;
  logic [StepBits-1:0] step_q, step_d;

  // State and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == KindSample) cmd_o.sample = 1'b1;
          if (in_kind_i == KindClear)  cmd_o.clear  = 1'b1;
          if (in_kind_i == KindRead)   state_d      = StDist;
        end
      end
      StDist: begin
        cmd_o.dist_calc = 1'b1;
        state_d         = StTurn;
      end
      StTurn: begin
        cmd_o.turn = 1'b1;
        state_d    = StHead;
      end
      StHead: begin
        cmd_o.head = 1'b1;
        step_d     = '0;
        state_d    = StCordic;
      end
      StCordic: begin
        cmd_o.cordic_step = 1'b1;
        step_d            = step_q + 1'b1;
        if (step_q == StepBits'(CordicSteps - 1)) state_d = StMulX;
      end
      StMulX: begin
        cmd_o.mul_x = 1'b1;
        state_d     = StMulY;
      end
      StMulY: begin
        cmd_o.mul_y = 1'b1;
        state_d     = StOut;
      end
      StOut: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// File: rtl/weo_datapath.sv
// Datapath: pulse counters, distance totals, heading, CORDIC and position update.
module weo_datapath
  import weo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        left_level_i,
  input  logic        right_level_i,
  input  logic [15:0] cm_per_pulse_i,
  input  logic [23:0] heading_gain_i,
  input  logic        out_ready_i,
  output logic        out_busy_o,
  output logic        out_valid_o,
  output logic [31:0] pos_x_o,
  output logic [31:0] pos_y_o,
  output logic [15:0] heading_o,
  output logic [31:0] left_total_o,
  output logic [31:0] right_total_o,
  output logic [31:0] mean_total_o
);

  logic                 lprev_q, rprev_q;
  logic [CountBits-1:0] lpend_q, rpend_q;
  logic [31:0]          ltot_q, rtot_q, x_q, y_q;
  logic [15:0]          head_q, mid_q;
  logic [31:0]          dl_q, dr_q, m_q;
  logic [56:0]          p_q;
  logic                 neg_q, flip_q;
  logic signed [33:0]   cx_q, cy_q;
  logic signed [32:0]   cz_q;
  logic [4:0]           idx_q;
  logic                 ovalid_q;

  // Interval distance with clamp.
  logic [CountBits+15:0] lprod, rprod;
  logic [31:0]           dl_d, dr_d;
  assign lprod = CountBits'(lpend_q) * cm_per_pulse_i;
  assign rprod = CountBits'(rpend_q) * cm_per_pulse_i;
  always_comb begin
    dl_d = (lprod > (CountBits+16)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : lprod[31:0];
    dr_d = (rprod > (CountBits+16)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : rprod[31:0];
  end

  // Heading change from the turn product.
  logic [31:0] mag;
  logic [15:0] full, half, full_s, half_s;
  logic [56:0] pr_full, pr_half;
  assign mag     = neg_q ? (dl_q - dr_q) : (dr_q - dl_q);
  assign pr_full = p_q + 57'd32768;
  assign pr_half = p_q + 57'd65536;
  assign full    = pr_full[31:16];
  assign half    = pr_half[32:17];
  assign full_s  = neg_q ? (16'd0 - full) : full;
  assign half_s  = neg_q ? (16'd0 - half) : half;

  // Angle folding for the CORDIC start.
  logic [31:0] a32, af;
  logic        fl;
  always_comb begin
    a32 = {mid_q, 16'd0};
    fl  = (a32 >= 32'h4000_0000) && (a32 < 32'hC000_0000);
    af  = fl ? (a32 - 32'h8000_0000) : a32;
  end

  // One CORDIC rotation.
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;
  assign xs = cx_q >>> idx_q;
  assign ys = cy_q >>> idx_q;
  assign at = $signed({1'b0, atan_lookup(idx_q)});

  // Scaling multiply, one axis per cycle.
  logic signed [33:0] cs;
  logic signed [67:0] prod;
  logic signed [67:0] prod_r;
  logic [31:0]        delta;
  assign cs     = cmd_i.mul_x ? (flip_q ? -cx_q : cx_q) : (flip_q ? -cy_q : cy_q);
  assign prod   = $signed({1'b0, m_q}) * cs;
  assign prod_r = prod + 68'sd536870912;
  assign delta  = prod_r[61:30];

  logic [32:0] lsum, rsum, msum;
  assign lsum = {1'b0, ltot_q} + {1'b0, dl_q};
  assign rsum = {1'b0, rtot_q} + {1'b0, dr_q};
  assign msum = {1'b0, ltot_q} + {1'b0, rtot_q};

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lprev_q  <= 1'b0;
      rprev_q  <= 1'b0;
      lpend_q  <= '0;
      rpend_q  <= '0;
      ltot_q   <= '0;
      rtot_q   <= '0;
      x_q      <= '0;
      y_q      <= '0;
      head_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.sample) begin
        if (left_level_i && !lprev_q && !(&lpend_q))  lpend_q <= lpend_q + 1'b1;
        if (right_level_i && !rprev_q && !(&rpend_q)) rpend_q <= rpend_q + 1'b1;
        lprev_q <= left_level_i;
        rprev_q <= right_level_i;
      end
      if (cmd_i.clear) begin
        lpend_q <= '0;
        rpend_q <= '0;
        lprev_q <= 1'b0;
        rprev_q <= 1'b0;
      end
      if (cmd_i.dist_calc) begin
        lpend_q <= '0;
        rpend_q <= '0;
      end
      if (cmd_i.turn) begin
        ltot_q <= lsum[32] ? 32'hFFFF_FFFF : lsum[31:0];
        rtot_q <= rsum[32] ? 32'hFFFF_FFFF : rsum[31:0];
      end
      if (cmd_i.head) head_q <= head_q + full_s;
      if (cmd_i.mul_x) x_q <= x_q + delta;
      if (cmd_i.mul_y) y_q <= y_q + delta;
      if (cmd_i.finish)    ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  // Working registers of one read beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.dist_calc) begin
      dl_q  <= dl_d;
      dr_q  <= dr_d;
      neg_q <= dr_d < dl_d;
      m_q   <= 32'(({1'b0, dl_d} + {1'b0, dr_d}) >> 1);
    end
    if (cmd_i.turn) p_q <= mag * heading_gain_i;
    if (cmd_i.head) mid_q <= head_q + half_s;
    if (cmd_i.head) idx_q <= '0;
    if (cmd_i.cordic_step) begin
      if (idx_q == 5'd0) begin
        // First step starts from the folded angle and the gain-corrected vector.
        if (!af[31]) begin
          cx_q <= CordicX0;
          cy_q <= CordicX0;
          cz_q <= $signed({af[31], af}) - at;
        end else begin
          cx_q <= CordicX0;
          cy_q <= -CordicX0;
          cz_q <= $signed({af[31], af}) + at;
        end
        flip_q <= fl;
      end else if (!cz_q[32]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.finish) begin
      pos_x_o       <= x_q;
      pos_y_o       <= y_q;
      heading_o     <= head_q;
      left_total_o  <= ltot_q;
      right_total_o <= rtot_q;
      mean_total_o  <= msum[32:1];
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_busy_o  = ovalid_q && !out_ready_i;

endmodule

// File: rtl/wheel_encoder_odometry.sv
// Top level of the wheel encoder odometry block: registers, controller, datapath.
//
//  Channel   Dir  Beat contents
//  s_axis    in   tuser: kind; tdata: left_level, right_level
//  m_axis    out  tdata: pos_x, pos_y, heading, left_total, right_total, mean_total
//  apb       in   cm_per_pulse at 0x0, heading_gain at 0x4
//
// Sample and clear beats are taken in the idle state. A read beat steps through the
// distance, turn, heading, CORDIC, multiply-x, multiply-y and output states, and no
// new beat is taken until it is back in idle; the CORDIC unit runs one step per cycle.
// Reset is asynchronous and active low; it clears the control state and sets the registers to their defaults.
// A read that ends while the previous result still waits on m_axis_tready holds
// in its last state until that beat is taken.
module wheel_encoder_odometry
  import weo_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,   // kind[1:0]
  input  logic [7:0]   s_axis_tdata,   // left_level[0], right_level[1]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], left_total[111:80],
  // right_total[143:112], mean_total[175:144]
  output logic [175:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0] cpp_q;
  logic [23:0] gain_q;
  cmd_t        cmd;
  logic        busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpp_q  <= 16'd256;
      gain_q <= 24'd205312;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      if (paddr[2] == RegCmPerPulse)  cpp_q  <= pwdata[15:0];
      if (paddr[2] == RegHeadingGain) gain_q <= pwdata[23:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegCmPerPulse) ? {16'd0, cpp_q} : {8'd0, gain_q};

  weo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_busy_i (busy),
    .cmd_o      (cmd)
  );

  weo_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .left_level_i   (s_axis_tdata[0]),
    .right_level_i  (s_axis_tdata[1]),
    .cm_per_pulse_i (cpp_q),
    .heading_gain_i (gain_q),
    .out_ready_i    (m_axis_tready),
    .out_busy_o     (busy),
    .out_valid_o    (m_axis_tvalid),
    .pos_x_o        (m_axis_tdata[31:0]),
    .pos_y_o        (m_axis_tdata[63:32]),
    .heading_o      (m_axis_tdata[79:64]),
    .left_total_o   (m_axis_tdata[111:80]),
    .right_total_o  (m_axis_tdata[143:112]),
    .mean_total_o   (m_axis_tdata[175:144])
  );

endmodule

// File: tb/wheel_encoder_odometry_tb.sv
// Self-checking testbench for the wheel encoder odometry block.
`timescale 1ns / 100ps

module wheel_encoder_odometry_tb;
  import weo_pkg::*;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned ReadCycles = CordicSteps + 6;
  localparam logic [31:0] CountMax = (32'd1 << CountBits) - 1;
  localparam logic [1:0]  KindUnused = 2'd3;

  // One expected result beat, last field in the highest bits.
  typedef struct packed {
    logic [31:0] mean_total;
    logic [31:0] right_total;
    logic [31:0] left_total;
    logic [15:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } odo_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser;   // kind[1:0]
  logic [7:0]   s_axis_tdata;   // left_level[0], right_level[1]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [175:0] m_axis_tdata;   // pos_x, pos_y, heading, left/right/mean total
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // Predictor state and register copies.
  logic [15:0] cm_per_pulse_q;
  logic [23:0] heading_gain_q;
  logic        left_prev_q, right_prev_q;
  logic [31:0] left_pend_q, right_pend_q;
  logic [31:0] left_dist_q, right_dist_q;
  logic [31:0] x_pos_q, y_pos_q;
  logic [15:0] head_q;

  odo_t pose_queue[$];
  bit   failed;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned stall_mode;

  wheel_encoder_odometry DUT (.*);

  // Clock.
  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  // Rotation-mode CORDIC on a 16-bit binary angle, results in Q30.
  function automatic void rotate(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    bit flip;
    longint x, y, z, nx;
    a = {ang, 16'h0};
    flip = 0;
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      a = a - 32'h8000_0000;
      flip = 1;
    end
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - floor_sh(y, i);
        y = y + floor_sh(x, i);
        z = z - longint'(atan_lookup(i[4:0]));
      end else begin
        nx = x + floor_sh(y, i);
        y = y - floor_sh(x, i);
        z = z + longint'(atan_lookup(i[4:0]));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] sat32(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Advance the odometry state by one accepted beat.
  function automatic void predict_odometry(logic [1:0] kind, logic ll, logic rl);
    longint unsigned dl, dr, m, mag, p;
    logic [15:0] full, half, mid;
    longint c, s, dx, dy;
    bit neg;
    odo_t r;
    if (kind == KindSample) begin
      if (ll && !left_prev_q && left_pend_q < CountMax) left_pend_q++;
      if (rl && !right_prev_q && right_pend_q < CountMax) right_pend_q++;
      left_prev_q = ll;
      right_prev_q = rl;
    end else if (kind == KindClear) begin
      left_pend_q = 0; right_pend_q = 0;
      left_prev_q = 0; right_prev_q = 0;
    end else if (kind == KindRead) begin
      dl = sat32(longint'(left_pend_q) * cm_per_pulse_q);
      dr = sat32(longint'(right_pend_q) * cm_per_pulse_q);
      m = (dl + dr) >> 1;
      neg = dr < dl;
      mag = neg ? dl - dr : dr - dl;
      p = mag * heading_gain_q;
      full = 16'((p + 32768) >> 16);
      half = 16'((p + 65536) >> 17);
      left_pend_q = 0; right_pend_q = 0;
      left_dist_q = sat32(longint'(left_dist_q) + dl);
      right_dist_q = sat32(longint'(right_dist_q) + dr);
      if (neg) begin
        full = -full;
        half = -half;
      end
      mid = head_q + half;
      head_q = head_q + full;
      rotate(mid, c, s);
      dx = floor_sh(longint'(m) * c + (64'sd1 <<< 29), 30);
      dy = floor_sh(longint'(m) * s + (64'sd1 <<< 29), 30);
      x_pos_q = x_pos_q + dx[31:0];
      y_pos_q = y_pos_q + dy[31:0];
      r.pos_x = x_pos_q;
      r.pos_y = y_pos_q;
      r.heading = head_q;
      r.left_total = left_dist_q;
      r.right_total = right_dist_q;
      r.mean_total = 32'((longint'(left_dist_q) + right_dist_q) >> 1);
      pose_queue.push_back(r);
    end
  endfunction

  // Send one input beat; valid stays high within a burst and drops in the gaps.
  task automatic send_beat(logic [1:0] kind, logic ll, logic rl);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {6'b0, rl, ll};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_odometry(kind, ll, rl);
    @(negedge clk_i);
  endtask

  // Register write over the configuration port; block must be idle.
  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pose_queue.size() != 0) @(negedge clk_i);
    repeat (ReadCycles + 4) @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == RegCmPerPulse) cm_per_pulse_q = val[15:0];
    else heading_gain_q = val[23:0];
  endtask

  // Send n full encoder cycles on the chosen wheels.
  task automatic pulse_wheels(int n, bit l, bit r);
    for (int i = 0; i < n; i++) begin
      send_beat(KindSample, l, r);
      send_beat(KindSample, 1'b0, 1'b0);
    end
  endtask

  task automatic test_directed();
    send_beat(KindRead, 1'b1, 1'b1);          // read with nothing pending, pins ignored
    pulse_wheels(3, 1'b1, 1'b0);
    send_beat(KindUnused, 1'b1, 1'b1);        // unused kind is ignored
    send_beat(KindRead, 1'b0, 1'b0);
    pulse_wheels(4, 1'b0, 1'b1);
    send_beat(KindSample, 1'b1, 1'b1);
    send_beat(KindSample, 1'b1, 1'b1);        // held level, no new edge
    send_beat(KindRead, 1'b0, 1'b0);
    pulse_wheels(2, 1'b1, 1'b1);
    send_beat(KindClear, 1'b1, 1'b1);
    send_beat(KindRead, 1'b0, 1'b0);
  endtask

  // A long unbroken run of left wheel edges at full rate.
  task automatic test_back_to_back();
    for (int i = 0; i < 100; i++) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tuser <= KindSample;
      s_axis_tdata <= {6'b0, 1'b0, i[0]};
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      predict_odometry(KindSample, i[0], 1'b0);
      @(negedge clk_i);
    end
    send_beat(KindRead, 1'b0, 1'b0);
  endtask

  task automatic test_random(int n);
    int k;
    logic l, r;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      l = 1'($urandom_range(0, 1));
      r = 1'($urandom_range(0, 1));
      if (k < 80) send_beat(KindSample, l, r);
      else if (k < 92) send_beat(KindRead, l, r);
      else if (k < 97) send_beat(KindClear, l, r);
      else send_beat(KindUnused, l, r);
    end
    send_beat(KindRead, 1'b0, 1'b0);
  endtask

  // Receiver stall pattern.
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (stall_mode == 0) m_axis_tready <= 1'b1;
    else if (stall_mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  // Result checker.
  always @(posedge clk_i) begin
    odo_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (psel && penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pose_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          failed = 1;
        end else begin
          want = pose_queue.pop_front();
          if (got.pos_x !== want.pos_x)
            $display("%0t: pos_x exp %h got %h", $time, want.pos_x, got.pos_x);
          if (got.pos_y !== want.pos_y)
            $display("%0t: pos_y exp %h got %h", $time, want.pos_y, got.pos_y);
          if (got.heading !== want.heading)
            $display("%0t: heading exp %h got %h", $time, want.heading, got.heading);
          if (got.left_total !== want.left_total)
            $display("%0t: left_total exp %h got %h", $time, want.left_total,
                     got.left_total);
          if (got.right_total !== want.right_total)
            $display("%0t: right_total exp %h got %h", $time, want.right_total,
                     got.right_total);
          if (got.mean_total !== want.mean_total)
            $display("%0t: mean_total exp %h got %h", $time, want.mean_total,
                     got.mean_total);
          if (got !== want) failed = 1;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat or register access.
  always @(posedge clk_i) begin
    if (idle_cycles > WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tuser = '0; s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    failed = 0; idle_cycles = 0; burst_left = 0; stall_mode = 0;
    cm_per_pulse_q = 16'd256; heading_gain_q = 24'd205312;
    left_prev_q = 0; right_prev_q = 0; left_pend_q = 0; right_pend_q = 0;
    left_dist_q = 0; right_dist_q = 0; x_pos_q = 0; y_pos_q = 0; head_q = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(140);
    write_reg(RegCmPerPulse, 32'd65535);
    write_reg(RegHeadingGain, 32'd16777215);
    test_back_to_back();
    test_random(110);
    write_reg(RegCmPerPulse, 32'd1);
    write_reg(RegHeadingGain, 32'd1);
    test_random(110);
    write_reg(RegCmPerPulse, 32'd0);
    write_reg(RegHeadingGain, 32'd0);
    test_random(40);
    write_reg(RegCmPerPulse, $urandom_range(1, 65535));
    write_reg(RegHeadingGain, $urandom_range(1, 16777215));
    test_random(110);

    s_axis_tvalid <= 1'b0;
    while (pose_queue.size() != 0) @(negedge clk_i);
    repeat (ReadCycles + 10) @(negedge clk_i);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/weo_pkg.sv
rtl/weo_ctrl.sv
rtl/weo_datapath.sv
rtl/wheel_encoder_odometry.sv
tb/wheel_encoder_odometry_tb.sv
